// ----- design/ler_pkg.sv -----
// Shared types and constants for the line edit receiver.
// No dependencies; imported by every module of the block.
package ler_pkg;

  // Longest line a request may ask for; longer requests are clamped.
  localparam int MaxLine = 4096;

  // Depth of the command queue between front and back.
  localparam int QueueDepthDef = 4;

  localparam logic [7:0] CharEot   = 8'd4;
  localparam logic [7:0] CharBs    = 8'd8;
  localparam logic [7:0] CharDel   = 8'd127;
  localparam logic [7:0] CharLf    = 8'd10;
  localparam logic [7:0] CharCr    = 8'd13;
  localparam logic [7:0] CharSpace = 8'd32;

  localparam logic ActBegin = 1'b0;
  localparam logic ActChar  = 1'b1;

  // One queued command: the first result beat, plus a flag for the
  // two trailing erase beats (space, backspace).
  typedef struct packed {
    logic        erase;
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic        store_valid;
    logic [11:0] store_index;
    logic [7:0]  store_byte;
    logic        done_res;
    logic [12:0] line_length;
  } cmd_t;

  // One result beat as it leaves the block.
  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_char;
    logic        store_valid;
    logic [11:0] store_index;
    logic [7:0]  store_byte;
    logic        done_res;
    logic [12:0] line_length;
    logic        last;
  } beat_t;

  typedef enum logic [2:0] {
    PhFirst = 3'b001,
    PhSpace = 3'b010,
    PhBs    = 3'b100
  } phase_e;

endpackage

// ----- design/line_edit_receiver.sv -----
// Line edit receiver: cooked-mode line input with echo and erase.
// Top level; instantiates ler_front, ler_queue and ler_back, uses ler_pkg.
//
// Usage:
//   Slave channel (s_axis_*): one beat per input item. tuser is the action
//   (0 opens a read request of request_length bytes, 1 delivers char_in).
//   Master channel (m_axis_*): one beat per result; tlast marks the final
//   result of an input item. A backspace/DEL above index zero gives three
//   beats (store+BS echo, space echo, BS echo); all other items give at
//   most one beat, and a begin with nonzero length or a character with no
//   open request gives none.
// Path: an accepted beat is written into the queue, then loaded from the
//   queue into the output register.
// Throughput: one input beat per cycle while the queue is not full. The line
//   state (open flag, write index, limit) is registered in the front end;
//   the back end emits one result beat per cycle while m_axis_tready is
//   high; an erase holds it for three beats while the queue absorbs more.
// Reset: no request open, index and limit zero, queue empty, no output.
// Stalls: when m_axis_tready is low the output register holds its beat and
//   the queue fills; s_axis_tready drops only once the queue is full.
module line_edit_receiver #(
  parameter int QueueDepth = ler_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item beats.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [12:0] request_length, [20:13] char_in, [23:21] zero
  input  logic [23:0] s_axis_tdata,
  // [0] action
  input  logic        s_axis_tuser,
  // Result beats.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] echo_valid, [8:1] echo_char, [9] store_valid, [21:10] store_index,
  // [29:22] store_byte, [30] done_res, [43:31] line_length, [47:44] zero
  output logic [47:0] m_axis_tdata,
  // last result of the input item
  output logic        m_axis_tlast
);
  import ler_pkg::*;

  localparam int CntW = $clog2(QueueDepth + 1);

  logic            push, pop, q_full, q_empty;
  cmd_t            push_cmd, pop_cmd;
  beat_t           out_beat;
  logic [CntW-1:0] q_count;

  // Front: classify characters and keep the line state.
  ler_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .action_i         (s_axis_tuser),
    .request_length_i (s_axis_tdata[12:0]),
    .char_in_i        (s_axis_tdata[20:13]),
    .queue_full_i     (q_full),
    .push_o           (push),
    .push_cmd_o       (push_cmd)
  );

  // Command queue between the two halves.
  ler_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_cmd),
    .count_o     (q_count)
  );

  // Back: expand commands into result beats.
  ler_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (q_empty),
    .queue_cmd_i   (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_beat_o    (out_beat)
  );

  assign m_axis_tdata = {4'b0, out_beat.line_length, out_beat.done_res,
                         out_beat.store_byte, out_beat.store_index,
                         out_beat.store_valid, out_beat.echo_char,
                         out_beat.echo_valid};
  assign m_axis_tlast = out_beat.last;

  // Queue occupancy never exceeds its depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(QueueDepth))
    else $error("command queue overfilled");

  // Only erase sequences give non-final beats, and each of those echoes.
  a_nonlast_echoes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> out_beat.echo_valid)
    else $error("non-final result beat without echo");

  // A finished line never reports more than the longest line.
  a_length_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_beat.done_res) |->
      ({4'b0, out_beat.line_length} <= 17'(MaxLine)))
    else $error("line length beyond limit");

  // The queue is only pushed when the queue has room for it.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full command queue");

endmodule

// ----- design/ler_front.sv -----
// Front end: accepts input beats, keeps the line state, emits commands.
// Depends on ler_pkg.
module ler_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          action_i,
  input  logic [12:0]   request_length_i,
  input  logic [7:0]    char_in_i,
  input  logic          queue_full_i,
  output logic          push_o,
  output ler_pkg::cmd_t push_cmd_o
);
  import ler_pkg::*;

  localparam logic [16:0] MaxLineW = 17'(MaxLine);

  logic        open_q, open_d;
  logic [12:0] index_q, index_d;
  logic [12:0] limit_q, limit_d;
  logic [12:0] req_c;
  logic [12:0] index_inc;
  logic        accept;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign index_inc  = index_q + 13'd1;

  always_comb begin
    if ({4'b0, request_length_i} > MaxLineW) begin
      req_c = MaxLineW[12:0];
    end else begin
      req_c = request_length_i;
    end
  end

  always_comb begin
    open_d     = open_q;
    index_d    = index_q;
    limit_d    = limit_q;
    push_o     = 1'b0;
    push_cmd_o = '0;
    if (accept) begin
      if (action_i == ActBegin) begin
        index_d = '0;
        if (req_c == '0) begin
          open_d                 = 1'b0;
          limit_d                = '0;
          push_o                 = 1'b1;
          push_cmd_o.done_res    = 1'b1;
        end else begin
          open_d  = 1'b1;
          limit_d = req_c;
        end
      end else if (open_q) begin
        push_o = 1'b1;
        case (char_in_i) inside
          CharEot: begin
            open_d                 = 1'b0;
            push_cmd_o.done_res    = 1'b1;
            push_cmd_o.line_length = index_q;
          end
          CharBs, CharDel: begin
            push_cmd_o.store_valid = 1'b1;
            if (index_q != '0) begin
              index_d                = index_q - 13'd1;
              push_cmd_o.erase       = 1'b1;
              push_cmd_o.echo_valid  = 1'b1;
              push_cmd_o.echo_char   = CharBs;
              push_cmd_o.store_index = index_q[11:0];
            end
          end
          CharLf, CharCr: begin
            open_d                 = 1'b0;
            push_cmd_o.echo_valid  = 1'b1;
            push_cmd_o.echo_char   = CharLf;
            push_cmd_o.store_valid = 1'b1;
            push_cmd_o.store_index = index_q[11:0];
            push_cmd_o.store_byte  = CharLf;
            push_cmd_o.done_res    = 1'b1;
            push_cmd_o.line_length = index_inc;
          end
          default: begin
            index_d                = index_inc;
            push_cmd_o.echo_valid  = 1'b1;
            push_cmd_o.echo_char   = char_in_i;
            push_cmd_o.store_valid = 1'b1;
            push_cmd_o.store_index = index_q[11:0];
            push_cmd_o.store_byte  = char_in_i;
            if (index_inc >= limit_q) begin
              open_d                 = 1'b0;
              push_cmd_o.done_res    = 1'b1;
              push_cmd_o.line_length = index_inc;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      index_q <= '0;
      limit_q <= '0;
    end else begin
      open_q  <= open_d;
      index_q <= index_d;
      limit_q <= limit_d;
    end
  end

endmodule

// ----- design/ler_queue.sv -----
// Small command FIFO decoupling front and back.
// Depends on ler_pkg for the command type.
module ler_queue #(
  parameter int Depth = ler_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ler_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ler_pkg::cmd_t pop_data_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);
  import ler_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == FullCnt);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];
  assign count_o    = cnt_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- design/ler_back.sv -----
// Back end: turns queued commands into result beats in an output register.
// Depends on ler_pkg.
module ler_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           queue_empty_i,
  input  ler_pkg::cmd_t  queue_cmd_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ler_pkg::beat_t out_beat_o
);
  import ler_pkg::*;

  phase_e phase_q, phase_d;
  logic   valid_q, valid_d;
  beat_t  beat_q, beat_d;
  logic   load;

  assign load        = !valid_q || out_ready_i;
  assign pop_o       = load && (phase_q == PhFirst) && !queue_empty_i;
  assign out_valid_o = valid_q;
  assign out_beat_o  = beat_q;

  always_comb begin
    phase_d = phase_q;
    valid_d = valid_q;
    beat_d  = beat_q;
    if (load) begin
      valid_d = 1'b0;
      case (phase_q)
        PhFirst: begin
          if (!queue_empty_i) begin
            valid_d            = 1'b1;
            beat_d.echo_valid  = queue_cmd_i.echo_valid;
            beat_d.echo_char   = queue_cmd_i.echo_char;
            beat_d.store_valid = queue_cmd_i.store_valid;
            beat_d.store_index = queue_cmd_i.store_index;
            beat_d.store_byte  = queue_cmd_i.store_byte;
            beat_d.done_res    = queue_cmd_i.done_res;
            beat_d.line_length = queue_cmd_i.line_length;
            beat_d.last        = !queue_cmd_i.erase;
            if (queue_cmd_i.erase) begin
              phase_d = PhSpace;
            end
          end
        end
        PhSpace: begin
          valid_d           = 1'b1;
          beat_d            = '0;
          beat_d.echo_valid = 1'b1;
          beat_d.echo_char  = CharSpace;
          phase_d           = PhBs;
        end
        PhBs: begin
          valid_d           = 1'b1;
          beat_d            = '0;
          beat_d.echo_valid = 1'b1;
          beat_d.echo_char  = CharBs;
          beat_d.last       = 1'b1;
          phase_d           = PhFirst;
        end
        default: begin
          phase_d = PhFirst;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhFirst;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

endmodule
